FILE: hdl/txrb_pkg.sv
// Package for the transmit ring: ring geometry, command codes and channel payload types.
`default_nettype none

package txrb_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int IDX_W      = 11;
    localparam int BYTE_W     = 8;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_DRAIN = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  read_index;
        logic              endpoint_present;
        logic              endpoint_busy;
        logic              endpoint_accepts;
    } t_in_item;

    typedef struct packed {
        logic              byte_accepted;
        logic              block_valid;
        logic [IDX_W-1:0]  block_start;
        logic [IDX_W-1:0]  block_length;
        logic [IDX_W-1:0]  free_bytes;
        logic              idle;
        logic [BYTE_W-1:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

endpackage

`default_nettype wire

FILE: hdl/txrb_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface txrb_in_if
    import txrb_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface txrb_out_if
    import txrb_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tx_ring_block_drain.sv
// Transmit ring buffer top level: input channel, ring control, byte RAM, result register.
//
// Usage:
//   i_in  carries one command per transfer: push a byte, drain event, flush,
//         or read a stored byte; endpoint state comes with each item.
//   o_out carries exactly one result per input transfer, in order.
//   The ring state and the RAM access are updated at the input transfer;
//   the RAM read data and the result, held in the middle stage, meet in
//   the output register when that stage advances.
//   Throughput is one item per cycle; the input stays ready while the output
//   register is empty or being taken in the same cycle.
//   When the receiver stalls, two items are held (one in the middle stage,
//   one in the output register) and i_in.ready drops until o_out moves.
//   Reset clears both pointers, the in-flight length and the valid flags;
//   the 2048-byte RAM is not cleared and a slot reads as junk until pushed.
`default_nettype none

module tx_ring_block_drain
    import txrb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    txrb_in_if.sink   i_in,
    txrb_out_if.source o_out
);

    t_out_item         ctrl_res;
    t_ram_wr           ram_wr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              accept, out_free, s1_adv, is_read;

    logic      r_s1_valid, n_s1_valid;
    t_out_item r_s1_res;
    logic      r_s1_rd;
    logic      r_o_valid, n_o_valid;
    t_out_item r_o_res, n_o_res;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign accept     = i_in.valid && i_in.ready;
    assign is_read    = (t_cmd'(i_in.data.cmd) == CMD_READ);

    txrb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in.data),
        .o_res    (ctrl_res),
        .o_ram_wr (ram_wr)
    );

    txrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (accept && is_read),
        .i_raddr (i_in.data.read_index[PTR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign n_s1_valid = accept || (r_s1_valid && !out_free);
    assign n_o_valid  = s1_adv || (r_o_valid && !o_out.ready);

    always_comb begin
        n_o_res           = r_s1_res;
        n_o_res.read_data = r_s1_rd ? ram_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= ctrl_res;
            r_s1_rd  <= is_read;
        end
        if (s1_adv) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_res;

endmodule

`default_nettype wire

FILE: hdl/txrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module txrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/txrb_ctrl.sv
// Ring pointer control: push, drain, flush, free count and idle per transfer.
`default_nettype none

module txrb_ctrl
    import txrb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    output      t_out_item o_res,
    output      t_ram_wr   o_ram_wr
);

    logic [PTR_W-1:0] r_wp, r_rp, r_ifl;
    logic [PTR_W-1:0] n_wp, n_rp, n_ifl;
    logic [PTR_W-1:0] free_now, free_next, rp_ret, size;
    logic             drain_ok;
    t_cmd             cmd;

    assign cmd      = t_cmd'(i_item.cmd);
    // power-of-two depth: free = rp - wp - 1 modulo depth
    assign free_now = r_rp - r_wp - PTR_W'(1);
    assign drain_ok = i_item.endpoint_present && !i_item.endpoint_busy;
    assign rp_ret   = r_rp + r_ifl;
    // run up to the wrap point, or up to the write pointer
    assign size     = (rp_ret > r_wp) ? (PTR_W'(0) - rp_ret) : (r_wp - rp_ret);

    always_comb begin
        n_wp           = r_wp;
        n_rp           = r_rp;
        n_ifl          = r_ifl;
        o_ram_wr.we    = 1'b0;
        o_ram_wr.addr  = r_wp;
        o_ram_wr.data  = i_item.data_byte;
        o_res          = '0;
        unique case (cmd)
            CMD_PUSH: begin
                if (free_now != '0) begin
                    o_ram_wr.we         = i_accept;
                    n_wp                = r_wp + PTR_W'(1);
                    o_res.byte_accepted = 1'b1;
                end
            end
            CMD_DRAIN: begin
                if (drain_ok) begin
                    n_rp  = rp_ret;
                    n_ifl = '0;
                    if (rp_ret != r_wp && i_item.endpoint_accepts) begin
                        n_ifl              = size;
                        o_res.block_valid  = 1'b1;
                        o_res.block_start  = IDX_W'(rp_ret);
                        o_res.block_length = IDX_W'(size);
                    end
                end
            end
            CMD_FLUSH: begin
                n_wp  = '0;
                n_rp  = '0;
                n_ifl = '0;
            end
            CMD_READ: begin
            end
            default: begin
            end
        endcase
        free_next        = n_rp - n_wp - PTR_W'(1);
        o_res.free_bytes = IDX_W'(free_next);
        o_res.idle       = (n_wp == n_rp) && (n_ifl == '0) &&
                           (!i_item.endpoint_present || !i_item.endpoint_busy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_ifl <= '0;
        end else if (i_accept) begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_ifl <= n_ifl;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tx_ring_block_drain_tb.sv
// Testbench for the transmit ring: directed table plus random command traffic, scoreboard check.
`timescale 1ns / 100ps

module tx_ring_block_drain_tb;
    import txrb_pkg::*;

    typedef struct {
        t_in_item  item;
        int        reps;
        bit        typed;
        t_out_item res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    txrb_in_if  in_ch ();
    txrb_out_if out_ch ();

    tx_ring_block_drain dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    bit                slot_written [RING_DEPTH];
    int                last_written;
    int                wr_ptr;
    int                rd_ptr;
    int                flight_len;

    t_out_item  result_q [$];
    t_stim_row  stim_tbl [$];
    int         errors;
    int         n_results;
    bit         calm;
    bit         stim_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int ring_free();
        if (rd_ptr <= wr_ptr) begin
            return RING_DEPTH - (wr_ptr - rd_ptr) - 1;
        end
        return rd_ptr - wr_ptr - 1;
    endfunction

    function automatic t_out_item ring_step(input t_in_item it);
        t_out_item r;
        int        size;
        r = '0;
        case (t_cmd'(it.cmd))
            CMD_PUSH: begin
                if (ring_free() != 0) begin
                    ring_mem[wr_ptr]     = it.data_byte;
                    slot_written[wr_ptr] = 1'b1;
                    last_written         = wr_ptr;
                    wr_ptr               = (wr_ptr + 1) % RING_DEPTH;
                    r.byte_accepted      = 1'b1;
                end
            end
            CMD_DRAIN: begin
                if (it.endpoint_present && !it.endpoint_busy) begin
                    if (flight_len != 0) begin
                        rd_ptr     = (rd_ptr + flight_len) % RING_DEPTH;
                        flight_len = 0;
                    end
                    if (rd_ptr != wr_ptr) begin
                        if (rd_ptr > wr_ptr) begin
                            size = RING_DEPTH - rd_ptr;
                        end else begin
                            size = wr_ptr - rd_ptr;
                        end
                        if (size > RING_DEPTH - 1) begin
                            size = RING_DEPTH - 1;
                        end
                        if (it.endpoint_accepts) begin
                            flight_len     = size;
                            r.block_valid  = 1'b1;
                            r.block_start  = IDX_W'(rd_ptr);
                            r.block_length = IDX_W'(size);
                        end
                    end
                end
            end
            CMD_FLUSH: begin
                wr_ptr     = 0;
                rd_ptr     = 0;
                flight_len = 0;
            end
            default: begin
                r.read_data = ring_mem[it.read_index % RING_DEPTH];
            end
        endcase
        r.idle = (wr_ptr == rd_ptr) && (flight_len == 0) &&
                 (!it.endpoint_present || !it.endpoint_busy);
        r.free_bytes = IDX_W'(ring_free());
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_out_item res_of(int acc, int bv, int bs, int bl, int fb, int idl,
                                         int rd);
        t_out_item r;
        r.byte_accepted = 1'(acc);
        r.block_valid   = 1'(bv);
        r.block_start   = IDX_W'(bs);
        r.block_length  = IDX_W'(bl);
        r.free_bytes    = IDX_W'(fb);
        r.idle          = 1'(idl);
        r.read_data     = BYTE_W'(rd);
        return r;
    endfunction

    task automatic add_row(t_cmd c, int dat, int idx, int pres, int busy, int acc, int reps,
                           int typed, t_out_item res);
        t_stim_row row;
        row.item.cmd              = c;
        row.item.data_byte        = BYTE_W'(dat);
        row.item.read_index       = IDX_W'(idx);
        row.item.endpoint_present = 1'(pres);
        row.item.endpoint_busy    = 1'(busy);
        row.item.endpoint_accepts = 1'(acc);
        row.reps                  = reps;
        row.typed                 = 1'(typed);
        row.res                   = res;
        stim_tbl.push_back(row);
    endtask

    function automatic t_in_item rand_item(t_cmd c);
        t_in_item it;
        it.cmd              = c;
        it.data_byte        = BYTE_W'($urandom);
        it.read_index       = IDX_W'($urandom);
        it.endpoint_present = 1'($urandom_range(0, 1));
        it.endpoint_busy    = 1'($urandom_range(0, 1));
        it.endpoint_accepts = 1'($urandom_range(0, 1));
        if (c == CMD_READ && !slot_written[it.read_index]) begin
            it.read_index = IDX_W'(last_written);
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item tres);
        int        gap;
        t_out_item pred;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = ring_step(it);
        result_q.push_back(typed ? tres : pred);
    endtask

    task automatic check_field(string name, logic [IDX_W-1:0] e, logic [IDX_W-1:0] a);
        if (a !== e) begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender
    initial begin
        t_in_item it;
        t_out_item none;
        int n_rand;
        int sel;
        int len;
        none         = '0;
        errors       = 0;
        calm         = 1'b0;
        stim_done    = 1'b0;
        wr_ptr       = 0;
        rd_ptr       = 0;
        flight_len   = 0;
        last_written = 0;
        foreach (slot_written[i]) slot_written[i] = 1'b0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;

        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 1, res_of(0, 0, 0, 0, 2047, 1, 0));
        add_row(CMD_PUSH, 8'h00, 0, 0, 0, 0, 1, 1, res_of(1, 0, 0, 0, 2046, 0, 0));
        add_row(CMD_PUSH, 8'hFF, 0, 0, 0, 0, 1, 1, res_of(1, 0, 0, 0, 2045, 0, 0));
        add_row(CMD_READ, 0, 0, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 2045, 0, 8'h00));
        add_row(CMD_READ, 0, 1, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 2045, 0, 8'hFF));
        add_row(CMD_DRAIN, 0, 0, 1, 1, 1, 1, 1, res_of(0, 0, 0, 0, 2045, 0, 0));
        add_row(CMD_DRAIN, 0, 0, 0, 0, 1, 1, 1, res_of(0, 0, 0, 0, 2045, 0, 0));
        add_row(CMD_DRAIN, 0, 0, 1, 0, 0, 1, 1, res_of(0, 0, 0, 0, 2045, 0, 0));
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 1, res_of(0, 1, 0, 2, 2045, 0, 0));
        add_row(CMD_PUSH, 8'h5A, 0, 0, 0, 0, 1, 0, none);
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 0, none);
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 0, none);
        add_row(CMD_FLUSH, 0, 0, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 2047, 1, 0));
        add_row(CMD_READ, 0, 2, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 2047, 1, 8'h5A));
        add_row(CMD_PUSH, 0, 0, 0, 0, 0, 2047, 0, none);
        add_row(CMD_PUSH, 8'hA5, 0, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_READ, 0, 2046, 0, 0, 0, 1, 0, none);
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 1, res_of(0, 1, 0, 2047, 0, 0, 0));
        add_row(CMD_PUSH, 8'h3C, 0, 0, 0, 0, 1, 1, res_of(0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_DRAIN, 0, 0, 1, 1, 1, 1, 1, res_of(0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 0, none);
        add_row(CMD_PUSH, 0, 0, 0, 0, 0, 2, 0, none);
        // wrap: block ends at the last slot, next one starts at zero
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 0, none);
        add_row(CMD_DRAIN, 0, 0, 1, 0, 1, 1, 0, none);

        while (i_rst_n !== 1'b1) @(posedge i_clk);

        foreach (stim_tbl[i]) begin
            for (int r = 0; r < stim_tbl[i].reps; r++) begin
                it = stim_tbl[i].item;
                if (stim_tbl[i].reps > 1) begin
                    it.data_byte = BYTE_W'($urandom);
                end
                send_item(it, stim_tbl[i].typed, stim_tbl[i].res);
            end
        end

        n_rand = 0;
        while (n_rand < 1350) begin
            calm = (n_rand >= 300) && (n_rand < 500);
            sel  = $urandom_range(0, 9);
            if (sel <= 5) begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
                                                   : $urandom_range(17, 250);
                repeat (len) begin
                    send_item(rand_item(CMD_PUSH), 1'b0, none);
                    n_rand++;
                end
            end else if (sel <= 7) begin
                repeat ($urandom_range(1, 3)) begin
                    it = rand_item(CMD_DRAIN);
                    it.endpoint_present = 1'b1;
                    it.endpoint_busy    = ($urandom_range(0, 9) == 0);
                    it.endpoint_accepts = ($urandom_range(0, 7) != 0);
                    send_item(it, 1'b0, none);
                    if (!it.endpoint_busy) n_rand++;
                end
            end else if (sel == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(rand_item(CMD_READ), 1'b0, none);
                    n_rand++;
                end
            end else begin
                it = rand_item(t_cmd'($urandom_range(0, 3)));
                send_item(it, 1'b0, none);
                if (!(it.cmd == CMD_DRAIN && (!it.endpoint_present || it.endpoint_busy))) begin
                    n_rand++;
                end
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver
    initial begin
        t_out_item exp_res;
        t_out_item got;
        int stall_left;
        bit pressed;
        n_results   = 0;
        stall_left  = 0;
        pressed     = 1'b0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                n_results++;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected transfer: expected none, got %h", $time, got);
                end else begin
                    exp_res = result_q.pop_front();
                    check_field("byte_accepted", IDX_W'(exp_res.byte_accepted),
                                IDX_W'(got.byte_accepted));
                    check_field("block_valid", IDX_W'(exp_res.block_valid),
                                IDX_W'(got.block_valid));
                    check_field("block_start", exp_res.block_start, got.block_start);
                    check_field("block_length", exp_res.block_length, got.block_length);
                    check_field("free_bytes", exp_res.free_bytes, got.free_bytes);
                    check_field("idle", IDX_W'(exp_res.idle), IDX_W'(got.idle));
                    check_field("read_data", IDX_W'(exp_res.read_data),
                                IDX_W'(got.read_data));
                end
            end
            // long hold-off while the sender keeps offering
            if (!pressed && n_results >= 500 && !stim_done) begin
                pressed    = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

endmodule
